// ===== sv/fcpr_pkg.sv =====
// Package for the framed command parser/responder.
// Holds the frame constants, parse phase codes, reply kinds and the reply byte table.
// No dependencies.
package fcpr_pkg;

  localparam logic [7:0] CH_U        = 8'h55;
  localparam logic [7:0] CH_N        = 8'h4E;
  localparam logic [7:0] CH_E        = 8'h45;
  localparam logic [7:0] CH_R        = 8'h52;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] ID_ACK      = 8'h0D;
  localparam logic [7:0] ID_ALIVE    = 8'hF0;
  localparam logic [7:0] ID_CONFIG   = 8'hEE;
  localparam logic [7:0] ID_UNKNOWN  = 8'hDD;
  localparam logic [7:0] LEN_ALIVE   = 8'h03;
  localparam logic [7:0] LEN_UNKNOWN = 8'h02;
  localparam logic [7:0] LEN_EMPTY   = 8'h00;

  localparam logic [7:0] HDR_CHK = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  localparam logic [7:0] CHK_ALIVE   = HDR_CHK ^ LEN_ALIVE ^ ID_ALIVE ^ ID_ACK;
  localparam logic [7:0] CHK_EMPTY   = HDR_CHK ^ LEN_EMPTY;
  localparam logic [7:0] CHK_UNKNOWN = HDR_CHK ^ LEN_UNKNOWN ^ ID_UNKNOWN;

  // parse phases
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_N     = 3'd1;
  localparam logic [2:0] PH_E     = 3'd2;
  localparam logic [2:0] PH_R     = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_TOKEN = 3'd5;
  localparam logic [2:0] PH_BODY  = 3'd6;

  typedef enum logic [1:0] {
    KIND_ALIVE,
    KIND_EMPTY,
    KIND_UNKNOWN
  } reply_kind_e;

  typedef logic [3:0] reply_idx_t;

  function automatic reply_idx_t reply_last_idx(reply_kind_e kind);
    reply_idx_t r;
    case (kind)
      KIND_ALIVE:   r = 4'd8;
      KIND_EMPTY:   r = 4'd6;
      default:      r = 4'd7;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] reply_byte(reply_kind_e kind, reply_idx_t idx);
    logic [7:0] b;
    case (idx)
      4'd0: b = CH_U;
      4'd1: b = CH_N;
      4'd2: b = CH_E;
      4'd3: b = CH_R;
      4'd4: begin
        case (kind)
          KIND_ALIVE: b = LEN_ALIVE;
          KIND_EMPTY: b = LEN_EMPTY;
          default:    b = LEN_UNKNOWN;
        endcase
      end
      4'd5: b = CH_COLON;
      4'd6: begin
        case (kind)
          KIND_ALIVE: b = ID_ALIVE;
          KIND_EMPTY: b = CHK_EMPTY;
          default:    b = ID_UNKNOWN;
        endcase
      end
      4'd7: begin
        case (kind)
          KIND_ALIVE: b = ID_ACK;
          default:    b = CHK_UNKNOWN;
        endcase
      end
      4'd8:    b = CHK_ALIVE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/framed_command_parser_responder_unit.sv =====
// Framed command parser/responder top level.
// Parses request frames from the rx byte channel and sends replies on the tx channel.
// Depends on fcpr_pkg.
//
// Channels: rx (rx_byte_i) and tx (tx_byte_o, tx_last_o), both valid/ready.
// Each accepted rx byte advances the frame parser in the cycle it is taken;
// parser state sits in registers, so one rx byte is taken per cycle while no
// reply is pending.
// A good checksum byte loads the reply register; the first reply beat is shown
// on the cycle after that byte is accepted. A reply is 7, 8 or 9 beats, one
// per cycle when tx_ready_i is high, with tx_last_o on its checksum beat.
// While a reply drains, rx_ready_o stays low; it rises again in the cycle the
// last beat is taken, so the next rx byte may overlap that beat.
// Throughput: 1 rx byte per cycle outside replies; a reply holds rx until its
// last beat is taken, and any tx stall lengthens that hold.
// Reset (rst_ni low, asynchronous) drops any reply in progress and returns
// the parser to hunting the first header byte.
// A tx stall holds the current beat and its payload unchanged.
module framed_command_parser_responder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_last_o
);

  logic [2:0] phase_q, phase_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] chk_q, chk_d;
  logic [7:0] cmd_q, cmd_d;
  logic       await_q, await_d;

  logic                 busy_q, busy_d;
  fcpr_pkg::reply_kind_e kind_q, kind_d;
  fcpr_pkg::reply_idx_t  idx_q, idx_d;

  logic       rx_fire, tx_fire, last_beat;
  logic       reply_go;
  logic [7:0] id_eff;
  logic [7:0] b;

  assign last_beat  = idx_q == fcpr_pkg::reply_last_idx(kind_q);
  assign tx_valid_o = busy_q;
  assign tx_byte_o  = fcpr_pkg::reply_byte(kind_q, idx_q);
  assign tx_last_o  = last_beat;
  assign tx_fire    = busy_q && tx_ready_i;
  assign rx_ready_o = !busy_q || (tx_ready_i && last_beat);
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign b          = rx_byte_i;
  assign id_eff     = await_q ? b : cmd_q;

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    chk_d    = chk_q;
    cmd_d    = cmd_q;
    await_d  = await_q;
    reply_go = 1'b0;
    if (rx_fire) begin
      case (phase_q)
        fcpr_pkg::PH_N, fcpr_pkg::PH_E, fcpr_pkg::PH_R: begin
          if ((phase_q == fcpr_pkg::PH_N && b == fcpr_pkg::CH_N) ||
              (phase_q == fcpr_pkg::PH_E && b == fcpr_pkg::CH_E) ||
              (phase_q == fcpr_pkg::PH_R && b == fcpr_pkg::CH_R)) begin
            phase_d = phase_q + 3'd1;
          end else begin
            phase_d = (b == fcpr_pkg::CH_U) ? fcpr_pkg::PH_N : fcpr_pkg::PH_HUNT;
            if (b == fcpr_pkg::CH_U) chk_d = 8'h00;
          end
        end
        fcpr_pkg::PH_LEN: begin
          rem_d   = b;
          phase_d = fcpr_pkg::PH_TOKEN;
        end
        fcpr_pkg::PH_TOKEN: begin
          if (b == fcpr_pkg::CH_COLON) begin
            chk_d   = fcpr_pkg::HDR_CHK ^ rem_q;
            rem_d   = (rem_q == 8'h00) ? 8'hFF : rem_q;
            await_d = 1'b1;
            phase_d = fcpr_pkg::PH_BODY;
          end else begin
            phase_d = (b == fcpr_pkg::CH_U) ? fcpr_pkg::PH_N : fcpr_pkg::PH_HUNT;
            if (b == fcpr_pkg::CH_U) chk_d = 8'h00;
          end
        end
        fcpr_pkg::PH_BODY: begin
          if (await_q) begin
            cmd_d   = b;
            await_d = 1'b0;
          end
          if (rem_q > 8'd1) begin
            chk_d = chk_q ^ b;
            rem_d = rem_q - 8'd1;
          end else begin
            rem_d    = 8'h00;
            reply_go = (chk_q == b);
            phase_d  = (b == fcpr_pkg::CH_U) ? fcpr_pkg::PH_N : fcpr_pkg::PH_HUNT;
            if (b == fcpr_pkg::CH_U) chk_d = 8'h00;
          end
        end
        default: begin
          phase_d = (b == fcpr_pkg::CH_U) ? fcpr_pkg::PH_N : fcpr_pkg::PH_HUNT;
          if (b == fcpr_pkg::CH_U) chk_d = 8'h00;
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    idx_d  = idx_q;
    if (tx_fire) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
    if (reply_go) begin
      busy_d = 1'b1;
      idx_d  = '0;
      if (id_eff == fcpr_pkg::ID_ALIVE) begin
        kind_d = fcpr_pkg::KIND_ALIVE;
      end else if (id_eff == fcpr_pkg::ID_CONFIG) begin
        kind_d = fcpr_pkg::KIND_EMPTY;
      end else begin
        kind_d = fcpr_pkg::KIND_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcpr_pkg::PH_HUNT;
      rem_q   <= 8'h00;
      chk_q   <= 8'h00;
      cmd_q   <= 8'h00;
      await_q <= 1'b0;
      busy_q  <= 1'b0;
      kind_q  <= fcpr_pkg::KIND_ALIVE;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      chk_q   <= chk_d;
      cmd_q   <= cmd_d;
      await_q <= await_d;
      busy_q  <= busy_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== sv/fcpr_checker.sv =====
// Port-level checker for the framed command parser/responder.
// Watches the top level's rx and tx channels; bound to the top level below.
// No package dependency.
module fcpr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic       tx_valid_o,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_o,
  input logic       tx_last_o
);

  // hold a stalled tx beat
  a_tx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && !tx_ready_i |=> tx_valid_o && $stable(tx_byte_o) && $stable(tx_last_o))
    else $error("tx beat changed while stalled");

  // drop rx ready while a reply drains
  a_rx_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && !(tx_ready_i && tx_last_o) |-> !rx_ready_o)
    else $error("rx ready during reply");

  // open a reply that starts on an idle tx channel with the first header byte
  a_reply_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_valid_o) |-> tx_byte_o == 8'h55)
    else $error("reply does not start with header");

  // start a reply only after an rx beat
  a_reply_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!tx_valid_o || (tx_ready_i && tx_last_o)) |=>
      !tx_valid_o || ($past(rx_valid_i && rx_ready_o) && tx_byte_o == 8'h55))
    else $error("reply without rx beat");

endmodule

bind framed_command_parser_responder_unit fcpr_checker u_fcpr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rx_valid_i (rx_valid_i),
  .rx_ready_o (rx_ready_o),
  .tx_valid_o (tx_valid_o),
  .tx_ready_i (tx_ready_i),
  .tx_byte_o  (tx_byte_o),
  .tx_last_o  (tx_last_o)
);
